// ===== rtl/core/asrt_pkg.sv =====
// Shared types, constants and helpers of the aging subnet route table.
package asrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int AGE_W       = 16;
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd120;

    typedef enum logic [1:0] {
        OP_ROUTE  = 2'd0,
        OP_PURGE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [31:0] network;
        logic [5:0]  prefix;
        logic [63:0] owner;
        logic [31:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic purge;
        logic reply;
    } t_ctl;

    typedef struct packed {
        logic scan_done;
        logic purge_done;
        logic is_route;
        logic last;
    } t_sts;

    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        logic [31:0] m;
        begin
            if (plen == 6'd0) begin
                m = 32'h0000_0000;
            end else if (plen >= 6'd32) begin
                m = 32'hFFFF_FFFF;
            end else begin
                m = ~(32'hFFFF_FFFF >> plen);
            end
            return m;
        end
    endfunction

endpackage

// ===== rtl/core/asrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module asrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/asrt_ctrl.sv =====
// Sequencing state machine of the route table.
module asrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_cmd,
    input  asrt_pkg::t_sts  i_sts,
    output asrt_pkg::t_ctl  o_ctl,
    output logic            busy
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_PURGE  = 5'b01000,
        ST_REPLY  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    unique case (asrt_pkg::t_op'(i_cmd)) inside
                        asrt_pkg::OP_ROUTE, asrt_pkg::OP_LOOKUP: n_state = ST_SCAN;
                        asrt_pkg::OP_PURGE:                      n_state = ST_PURGE;
                        default:                                 n_state = ST_REPLY;
                    endcase
                end
            end
            ST_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.is_route ? ST_UPDATE : ST_REPLY;
                end
            end
            ST_UPDATE: begin
                o_ctl.update = 1'b1;
                n_state = i_sts.last ? ST_PURGE : ST_REPLY;
            end
            ST_PURGE: begin
                o_ctl.purge = 1'b1;
                if (i_sts.purge_done) begin
                    n_state = ST_REPLY;
                end
            end
            ST_REPLY: begin
                o_ctl.reply = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/asrt_dp.sv =====
// Datapath of the route table: entry RAM, scan and compaction pointers, result.
module asrt_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  asrt_pkg::t_ctl               i_ctl,
    output asrt_pkg::t_sts               o_sts,
    input  logic                         i_cfg_we,
    input  logic [asrt_pkg::AGE_W-1:0]   i_cfg_data,
    input  logic [1:0]                   i_cmd,
    input  logic [31:0]                  i_subnet_network,
    input  logic [5:0]                   i_subnet_prefix,
    input  logic [63:0]                  i_owner_id,
    input  logic                         i_batch_end,
    input  logic [31:0]                  i_now_seconds,
    input  logic [31:0]                  i_query_address,
    output logic                         o_done,
    output logic                         o_found,
    output logic [63:0]                  o_found_owner,
    output logic                         o_dropped,
    output logic [asrt_pkg::CNT_W-1:0]   o_entry_count
);

    localparam logic [asrt_pkg::CNT_W-1:0] FULL = asrt_pkg::CNT_W'(asrt_pkg::TABLE_DEPTH);

    logic [asrt_pkg::AGE_W-1:0] r_max_age;
    asrt_pkg::t_op              r_cmd;
    logic [31:0]                r_net;
    logic [5:0]                 r_plen;
    logic [63:0]                r_owner;
    logic                       r_last;
    logic [31:0]                r_now;
    logic [31:0]                r_addr;

    logic [asrt_pkg::CNT_W-1:0] r_count;
    logic [asrt_pkg::CNT_W-1:0] r_rd_idx;
    logic [asrt_pkg::CNT_W-1:0] n_rd_idx;
    logic [asrt_pkg::CNT_W-1:0] r_wr_ptr;
    logic [asrt_pkg::CNT_W-1:0] n_wr_ptr;
    logic                       r_chk_vld;
    logic                       n_chk_vld;
    logic [asrt_pkg::IDX_W-1:0] r_chk_idx;
    logic                       r_hit;
    logic [asrt_pkg::IDX_W-1:0] r_hit_idx;
    logic [63:0]                r_hit_owner;
    logic                       r_dropped;

    logic                       rd_en;
    logic                       step;
    logic                       route_eq;
    logic                       look_eq;
    logic                       match_now;
    logic                       keep;
    logic [31:0]                age;
    logic                       ram_we;
    logic [asrt_pkg::IDX_W-1:0] ram_waddr;
    asrt_pkg::t_entry           ram_wdata;
    asrt_pkg::t_entry           rdata;
    asrt_pkg::t_entry           new_entry;

    asrt_ram #(
        .WIDTH (asrt_pkg::ENTRY_W),
        .DEPTH (asrt_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[asrt_pkg::IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign step  = i_ctl.scan | i_ctl.purge;
    assign rd_en = step && (r_rd_idx < r_count);

    assign route_eq  = (rdata.network == r_net) && (rdata.prefix == r_plen)
                    && (rdata.owner == r_owner);
    assign look_eq   = ((r_addr & asrt_pkg::prefix_mask(rdata.prefix)) == rdata.network);
    assign match_now = r_chk_vld && ((r_cmd == asrt_pkg::OP_ROUTE) ? route_eq : look_eq);

    assign age  = r_now - rdata.stamp;
    assign keep = (age <= {16'd0, r_max_age});

    assign o_sts.scan_done  = match_now || (!r_chk_vld && (r_rd_idx >= r_count));
    assign o_sts.purge_done = !r_chk_vld && (r_rd_idx >= r_count);
    assign o_sts.is_route   = (r_cmd == asrt_pkg::OP_ROUTE);
    assign o_sts.last       = r_last;

    assign new_entry = '{network: r_net, prefix: r_plen, owner: r_owner, stamp: r_now};

    always_comb begin
        n_rd_idx  = '0;
        n_wr_ptr  = '0;
        n_chk_vld = 1'b0;
        if (step) begin
            n_rd_idx  = rd_en ? r_rd_idx + 1'b1 : r_rd_idx;
            n_chk_vld = rd_en;
        end
        if (i_ctl.purge) begin
            n_wr_ptr = (r_chk_vld && keep) ? r_wr_ptr + 1'b1 : r_wr_ptr;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_ptr[asrt_pkg::IDX_W-1:0];
        ram_wdata = rdata;
        if (i_ctl.update) begin
            ram_wdata = new_entry;
            if (r_hit) begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx;
            end else if (r_count < FULL) begin
                ram_we    = 1'b1;
                ram_waddr = r_count[asrt_pkg::IDX_W-1:0];
            end
        end else if (i_ctl.purge) begin
            ram_we = r_chk_vld && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= asrt_pkg::MAX_AGE_RESET;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_wr_ptr  <= '0;
            r_chk_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_dropped <= 1'b0;
            o_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
            r_rd_idx  <= n_rd_idx;
            r_wr_ptr  <= n_wr_ptr;
            r_chk_vld <= n_chk_vld;
            o_done    <= i_ctl.reply;
            if (i_ctl.load) begin
                r_hit     <= 1'b0;
                r_dropped <= 1'b0;
            end
            if (i_ctl.scan && match_now) begin
                r_hit <= 1'b1;
            end
            if (i_ctl.update) begin
                if (!r_hit) begin
                    if (r_count < FULL) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end
            end
            if (i_ctl.purge && o_sts.purge_done) begin
                r_count <= r_wr_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= asrt_pkg::t_op'(i_cmd);
            r_net   <= i_subnet_network;
            r_plen  <= i_subnet_prefix;
            r_owner <= i_owner_id;
            r_last  <= i_batch_end;
            r_now   <= i_now_seconds;
            r_addr  <= i_query_address;
        end
        if (rd_en) begin
            r_chk_idx <= r_rd_idx[asrt_pkg::IDX_W-1:0];
        end
        if (i_ctl.scan && match_now) begin
            r_hit_idx   <= r_chk_idx;
            r_hit_owner <= rdata.owner;
        end
        if (i_ctl.reply) begin
            o_found       <= r_hit && (r_cmd == asrt_pkg::OP_LOOKUP);
            o_found_owner <= (r_hit && (r_cmd == asrt_pkg::OP_LOOKUP)) ? r_hit_owner : 64'd0;
            o_dropped     <= r_dropped;
            o_entry_count <= r_count;
        end
    end

endmodule

// ===== rtl/core/aging_subnet_route_table.sv =====
// Top level of the aging subnet route table.
//
// An item is taken when start is high and busy is low; its one result beat
// appears on the o_ ports for a single cycle with o_done high and cannot be
// held off. busy stays high from the accept edge until the result beat is
// shown, and the next item may start in that beat cycle. Entries are read one
// per cycle out of the entry RAM (registered read); a scan stops at the first
// matching entry or after the last entry. A lookup is busy for its scan plus a
// reply state, a route item for its scan plus an update and a reply state, and
// an unused command for the reply state alone. A purge item is busy for a
// purge pass plus a reply state, and a route item that ends a batch adds the
// pass after its update. The worst case is a batch-ending route item that
// misses in a full table. busy falls in the cycle the result beat is shown.
module aging_subnet_route_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [asrt_pkg::AGE_W-1:0]  i_cfg_data,
    input  logic [1:0]                  i_cmd,
    input  logic [31:0]                 i_subnet_network,
    input  logic [5:0]                  i_subnet_prefix,
    input  logic [63:0]                 i_owner_id,
    input  logic                        i_batch_end,
    input  logic [31:0]                 i_now_seconds,
    input  logic [31:0]                 i_query_address,
    output logic                        o_done,
    output logic                        o_found,
    output logic [63:0]                 o_found_owner,
    output logic                        o_dropped,
    output logic [asrt_pkg::CNT_W-1:0]  o_entry_count
);

    asrt_pkg::t_ctl ctl;
    asrt_pkg::t_sts sts;

    asrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    asrt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_subnet_network (i_subnet_network),
        .i_subnet_prefix  (i_subnet_prefix),
        .i_owner_id       (i_owner_id),
        .i_batch_end      (i_batch_end),
        .i_now_seconds    (i_now_seconds),
        .i_query_address  (i_query_address),
        .o_done           (o_done),
        .o_found          (o_found),
        .o_found_owner    (o_found_owner),
        .o_dropped        (o_dropped),
        .o_entry_count    (o_entry_count)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat shown while busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_entry_count <= asrt_pkg::CNT_W'(asrt_pkg::TABLE_DEPTH)))
        else $error("entry count beyond table depth");

    a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_found_owner == 64'd0))
        else $error("owner nonzero without a match");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_found && o_dropped))
        else $error("lookup hit and drop in one beat");

endmodule
